FILE: src/sat_pkg.sv
package sat_pkg;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [7:0] MAX_ARGS_RESET = 8'd64;
  localparam logic [7:0] COUNT_MAX      = 8'hFF;
  localparam int         QUEUE_DEPTH    = 4;

  // One classified item: the back end turns it into one result, or two when
  // a kept backslash has to go out ahead of the byte.
  typedef struct packed {
    logic       esc_first;
    logic [7:0] ch;
    logic       ch_valid;
    logic       begin_arg;
    logic       end_arg;
    logic [7:0] count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/sat_in_if.sv
interface sat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_end;

  modport source(output valid, char_in, is_end, input ready);
  modport sink(input valid, char_in, is_end, output ready);
endinterface

FILE: src/sat_out_if.sv
interface sat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       arg_begin;
  logic       arg_end;
  logic [7:0] arg_count;
  logic       last;

  modport source(output valid, out_char, char_valid, arg_begin, arg_end, arg_count, last,
                 input ready);
  modport sink(input valid, out_char, char_valid, arg_begin, arg_end, arg_count, last,
               output ready);
endinterface

FILE: src/shell_argument_tokenizer.sv
// Channel   Role    Payload                                               Accepted when
// in_ch     sink    char_in, is_end                                       valid && ready
// out_ch    source  out_char, char_valid, arg_begin, arg_end, arg_count,  valid && ready
//                   last
// cfg       write   cfg_wdata (max_args)                                  cfg_we
//
// One input item is taken per cycle while the command queue has room.
// An item that produces a result is written into the command queue and then loaded into the output register.
// An escaped byte inside double quotes that keeps its backslash goes out as two results, backslash first.
// Reset is synchronous and clears the lexer state, empties the queue and drops the output valid.
// A stalled output fills the queue, and the input then stalls until an entry drains.
module shell_argument_tokenizer #(
  parameter int QUEUE_DEPTH = sat_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  sat_in_if.sink     in_ch,
  sat_out_if.source  out_ch
);

  sat_pkg::cmd_t    wr_cmd;
  sat_pkg::cmd_t    head;
  sat_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  sat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (wr_cmd)
  );

  sat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  sat_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: src/sat_front.sv
module sat_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata,
  sat_in_if.sink           in_ch,
  input  sat_pkg::q_stat_t q_stat,
  output logic             push,
  output sat_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    M_BETWEEN = 3'd0,
    M_IN_ARG  = 3'd1,
    M_ESC     = 3'd2,
    M_QUOTE   = 3'd3,
    M_QESC    = 3'd4
  } mode_t;

  mode_t      mode, mode_next;
  logic       qdbl, qdbl_next;
  logic [7:0] args_done, args_done_next;
  logic [7:0] max_args;
  logic [7:0] done_inc;
  logic [7:0] c;
  logic       term, blank, is_quote, accept, emit, closed;

  assign c        = in_ch.char_in;
  assign term     = in_ch.is_end || (c == sat_pkg::CH_NUL);
  assign blank    = (c == sat_pkg::CH_SPACE) || (c >= sat_pkg::CH_TAB && c <= sat_pkg::CH_CR);
  assign is_quote = (c == sat_pkg::CH_DQUOTE) || (c == sat_pkg::CH_SQUOTE);
  assign done_inc = (args_done == sat_pkg::COUNT_MAX) ? args_done : args_done + 8'd1;
  assign in_ch.ready = !q_stat.full;
  assign accept   = in_ch.valid && in_ch.ready;
  assign push     = accept && emit;
  assign closed   = (mode != M_BETWEEN);

  always_comb begin
    mode_next      = mode;
    qdbl_next      = qdbl;
    args_done_next = args_done;
    emit           = 1'b0;
    cmd            = '0;
    cmd.count      = args_done;
    if (term) begin
      emit           = 1'b1;
      cmd.end_arg    = closed;
      cmd.count      = closed ? done_inc : args_done;
      mode_next      = M_BETWEEN;
      qdbl_next      = 1'b0;
      args_done_next = 8'd0;
    end else if (args_done < max_args) begin
      case (mode)
        M_IN_ARG: begin
          if (blank) begin
            emit           = 1'b1;
            cmd.end_arg    = 1'b1;
            cmd.count      = done_inc;
            args_done_next = done_inc;
            mode_next      = M_BETWEEN;
          end else if (is_quote) begin
            qdbl_next = (c == sat_pkg::CH_DQUOTE);
            mode_next = M_QUOTE;
          end else if (c == sat_pkg::CH_BSLASH) begin
            mode_next = M_ESC;
          end else begin
            emit         = 1'b1;
            cmd.ch       = c;
            cmd.ch_valid = 1'b1;
          end
        end
        M_ESC: begin
          emit         = 1'b1;
          cmd.ch       = c;
          cmd.ch_valid = 1'b1;
          mode_next    = M_IN_ARG;
        end
        M_QUOTE: begin
          if (c == (qdbl ? sat_pkg::CH_DQUOTE : sat_pkg::CH_SQUOTE)) begin
            mode_next = M_IN_ARG;
          end else if (qdbl && c == sat_pkg::CH_BSLASH) begin
            mode_next = M_QESC;
          end else begin
            emit         = 1'b1;
            cmd.ch       = c;
            cmd.ch_valid = 1'b1;
          end
        end
        M_QESC: begin
          emit          = 1'b1;
          cmd.ch        = c;
          cmd.ch_valid  = 1'b1;
          cmd.esc_first = (c != sat_pkg::CH_DQUOTE) && (c != sat_pkg::CH_BSLASH);
          mode_next     = M_QUOTE;
        end
        default: begin
          if (blank) begin
            mode_next = M_BETWEEN;
          end else if (is_quote) begin
            qdbl_next     = (c == sat_pkg::CH_DQUOTE);
            emit          = 1'b1;
            cmd.begin_arg = 1'b1;
            mode_next     = M_QUOTE;
          end else if (c == sat_pkg::CH_BSLASH) begin
            emit          = 1'b1;
            cmd.begin_arg = 1'b1;
            mode_next     = M_ESC;
          end else begin
            emit          = 1'b1;
            cmd.ch        = c;
            cmd.ch_valid  = 1'b1;
            cmd.begin_arg = 1'b1;
            mode_next     = M_IN_ARG;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_BETWEEN;
      qdbl      <= 1'b0;
      args_done <= 8'd0;
      max_args  <= sat_pkg::MAX_ARGS_RESET;
    end else begin
      if (cfg_we) begin
        max_args <= cfg_wdata;
      end
      if (accept) begin
        mode      <= mode_next;
        qdbl      <= qdbl_next;
        args_done <= args_done_next;
      end
    end
  end

endmodule

FILE: src/sat_queue.sv
module sat_queue #(
  parameter int DEPTH = sat_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sat_pkg::cmd_t    wr_cmd,
  input  logic             pop,
  output sat_pkg::cmd_t    head,
  output sat_pkg::q_stat_t q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sat_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/sat_back.sv
module sat_back (
  input  logic             clk,
  input  logic             rst,
  input  sat_pkg::cmd_t    head,
  input  sat_pkg::q_stat_t q_stat,
  output logic             pop,
  sat_out_if.source        out_ch
);

  logic       ovalid;
  logic       phase;
  logic [7:0] o_char;
  logic       o_cvalid, o_begin, o_end, o_last;
  logic [7:0] o_count;
  logic       load, take, split;

  assign load  = !ovalid || out_ch.ready;
  assign take  = load && !q_stat.empty;
  assign split = head.esc_first && !phase;
  assign pop   = take && !split;

  assign out_ch.valid      = ovalid;
  assign out_ch.out_char   = o_char;
  assign out_ch.char_valid = o_cvalid;
  assign out_ch.arg_begin  = o_begin;
  assign out_ch.arg_end    = o_end;
  assign out_ch.arg_count  = o_count;
  assign out_ch.last       = o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      phase  <= 1'b0;
    end else if (take) begin
      ovalid <= 1'b1;
      phase  <= split;
    end else if (load) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_count <= head.count;
      if (split) begin
        o_char   <= sat_pkg::CH_BSLASH;
        o_cvalid <= 1'b1;
        o_begin  <= 1'b0;
        o_end    <= 1'b0;
        o_last   <= 1'b0;
      end else begin
        o_char   <= head.ch;
        o_cvalid <= head.ch_valid;
        o_begin  <= head.begin_arg;
        o_end    <= head.end_arg;
        o_last   <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_split_shown: assert property (@(posedge clk) disable iff (rst)
    phase |-> (ovalid && o_char == sat_pkg::CH_BSLASH && !o_last))
    else $error("kept backslash not on the output");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !o_cvalid) |-> (o_char == sat_pkg::CH_NUL))
    else $error("byte field not zero without a byte");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (ovalid && o_end) |-> (o_last && !o_cvalid && !o_begin))
    else $error("argument close on a wrong result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from an empty queue");
`endif

endmodule
